>>> rtl/bdb_pkg.sv
// ----------------------------------------------------------------------------
// bdb_pkg
// Shared types, constants and geometry helpers for the Bayer demosaic binner.
// ----------------------------------------------------------------------------
package bdb_pkg;

  localparam int MAX_WIDTH  = 4096;
  localparam int MAX_HEIGHT = 4096;

  localparam int PIX_W     = 10;
  localparam int SUM_W     = 12;
  localparam int OUT_POS_W = 11;
  localparam int CFG_W     = 13;
  localparam int CFG_IDX_W = 1;

  localparam int COL_W = $clog2(MAX_WIDTH);
  localparam int ROW_W = $clog2(MAX_HEIGHT);
  localparam int DIM_W = (COL_W + 1 > CFG_W) ? COL_W + 1 : CFG_W;

  localparam int RESET_WIDTH  = 3280;
  localparam int RESET_HEIGHT = 2464;

  localparam logic [CFG_IDX_W-1:0] REG_FRAME_WIDTH  = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_FRAME_HEIGHT = CFG_IDX_W'(1);

  typedef logic [PIX_W-1:0]        pix_t;
  typedef logic [2:0][PIX_W-1:0]   lines_t;
  typedef logic [3:0][PIX_W-1:0]   column_t;
  typedef logic [SUM_W-1:0]        sum_t;

  typedef struct packed {
    logic                 emit;
    logic                 row_end;
    logic                 frame_end;
    logic [OUT_POS_W-1:0] out_col;
    logic [OUT_POS_W-1:0] out_row;
  } tag_t;

  typedef struct packed {
    sum_t blue;
    sum_t green;
    sum_t red;
  } rgb_t;

  function automatic logic [DIM_W-1:0] eff_dim(input logic [CFG_W-1:0] v,
                                               input logic [DIM_W-1:0] hi);
    logic [DIM_W-1:0] x;
    x = DIM_W'(v);
    if (x < DIM_W'(4)) x = DIM_W'(4);
    if (x > hi) x = hi;
    x[0] = 1'b0;
    return x;
  endfunction

endpackage

>>> rtl/bdb_ram.sv
// ----------------------------------------------------------------------------
// bdb_ram
// Generic single-write, single-read synchronous RAM with registered read.
// ----------------------------------------------------------------------------
module bdb_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

>>> rtl/bdb_ctrl.sv
// ----------------------------------------------------------------------------
// bdb_ctrl
// Geometry registers, raster counters and per-item output tags.
// ----------------------------------------------------------------------------
module bdb_ctrl
  import bdb_pkg::*;
(
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_valid_i,
  input  logic [CFG_IDX_W-1:0] cfg_index_i,
  input  logic [CFG_W-1:0]     cfg_data_i,
  input  logic                 accept_i,
  input  logic                 frame_start_i,
  output logic [COL_W-1:0]     addr_o,
  output tag_t                 tag_o
);

  logic [DIM_W-1:0] width_q, height_q;
  logic [COL_W-1:0] col_q, col_d, c;
  logic [ROW_W-1:0] row_q, row_d, r;
  logic [DIM_W-1:0] c_ext, r_ext, c_nxt, r_nxt, c_off, r_off;
  logic             wrap;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= eff_dim(CFG_W'(RESET_WIDTH), DIM_W'(MAX_WIDTH));
      height_q <= eff_dim(CFG_W'(RESET_HEIGHT), DIM_W'(MAX_HEIGHT));
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        REG_FRAME_WIDTH:  width_q  <= eff_dim(cfg_data_i, DIM_W'(MAX_WIDTH));
        REG_FRAME_HEIGHT: height_q <= eff_dim(cfg_data_i, DIM_W'(MAX_HEIGHT));
        default: ;
      endcase
    end
  end

  always_comb begin
    c     = frame_start_i ? '0 : col_q;
    r     = frame_start_i ? '0 : row_q;
    c_ext = DIM_W'(c);
    r_ext = DIM_W'(r);
    c_nxt = c_ext + DIM_W'(1);
    r_nxt = r_ext + DIM_W'(1);
    wrap  = (c_nxt >= width_q);
    col_d = wrap ? '0 : c_nxt[COL_W-1:0];
    if (!wrap) begin
      row_d = r;
    end else if (r_nxt >= height_q) begin
      row_d = '0;
    end else begin
      row_d = r_nxt[ROW_W-1:0];
    end
    c_off = (c_ext - DIM_W'(3)) >> 1;
    r_off = (r_ext - DIM_W'(3)) >> 1;

    tag_o.emit      = c[0] && r[0] && (c != COL_W'(1)) && (r != ROW_W'(1))
                      && (c_ext < width_q) && (r_ext < height_q);
    tag_o.row_end   = (c_ext == width_q - DIM_W'(1));
    tag_o.frame_end = tag_o.row_end && (r_ext == height_q - DIM_W'(1));
    tag_o.out_col   = c_off[OUT_POS_W-1:0];
    tag_o.out_row   = r_off[OUT_POS_W-1:0];
  end

  assign addr_o = c;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q <= '0;
      row_q <= '0;
    end else if (accept_i) begin
      col_q <= col_d;
      row_q <= row_d;
    end
  end

endmodule

>>> rtl/bdb_kernel.sv
// ----------------------------------------------------------------------------
// bdb_kernel
// 4x4 window of Bayer samples and bilinear 2x2 binned RGB sums.
// ----------------------------------------------------------------------------
module bdb_kernel
  import bdb_pkg::*;
(
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    advance_i,
  input  column_t column_i,
  output rgb_t    rgb_o
);

  column_t win_q [3];
  pix_t    d [4][4];

  function automatic sum_t add2(input pix_t a, input pix_t b);
    return SUM_W'(a) + SUM_W'(b);
  endfunction

  function automatic sum_t add4(input pix_t a, input pix_t b, input pix_t c, input pix_t e);
    return SUM_W'(a) + SUM_W'(b) + SUM_W'(c) + SUM_W'(e);
  endfunction

  always_comb begin
    for (int j = 0; j < 4; j++) begin
      d[j][3] = column_i[j];
      d[j][2] = win_q[0][j];
      d[j][1] = win_q[1][j];
      d[j][0] = win_q[2][j];
    end
    rgb_o.red   = SUM_W'(d[1][1]) + (add2(d[1][1], d[1][3]) >> 1)
                  + (add2(d[1][1], d[3][1]) >> 1)
                  + (add4(d[1][1], d[1][3], d[3][1], d[3][3]) >> 2);
    rgb_o.green = (add4(d[0][1], d[1][0], d[2][1], d[1][2]) >> 2)
                  + SUM_W'(d[1][2]) + SUM_W'(d[2][1])
                  + (add4(d[1][2], d[2][3], d[3][2], d[2][1]) >> 2);
    rgb_o.blue  = (add4(d[0][0], d[2][0], d[0][2], d[2][2]) >> 2)
                  + (add2(d[0][2], d[2][2]) >> 1)
                  + (add2(d[2][0], d[2][2]) >> 1) + SUM_W'(d[2][2]);
  end

  // shift window one column left
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < 3; k++) begin
        win_q[k] <= '0;
      end
    end else if (advance_i) begin
      win_q[2] <= win_q[1];
      win_q[1] <= win_q[0];
      win_q[0] <= column_i;
    end
  end

endmodule

>>> rtl/bayer_demosaic_bin2x2.sv
// ----------------------------------------------------------------------------
// bayer_demosaic_bin2x2
// Bilinear BGGR demosaic with 2x2 binning over a raster sample stream.
// ----------------------------------------------------------------------------
// channel   dir  handshake               payload
// s_axis    in   tvalid / tready         tdata: sample; tuser: frame_start
// m_axis    out  tvalid / tready         tdata: red, green, blue, col, row;
//                                        tlast: row_end; tuser: frame_end
// cfg       in   cfg_valid / cfg_ready   cfg_index, cfg_data
//
// One item per cycle while the result side is not stalled. The registered
// line-store read of an accepted item sets the first stage, the binning
// adders the second. The line store holds one word of three rows per column,
// read and written back in the same column sweep, with forwarding on an
// address match. A stalled result blocks the input once one more item waits
// in the first stage; input resumes as soon as the result is taken. No
// clearing pass after reset.
// ----------------------------------------------------------------------------
module bayer_demosaic_bin2x2
  import bdb_pkg::*;
(
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 s_axis_tvalid_i,
  output logic                 s_axis_tready_o,
  input  logic [15:0]          s_axis_tdata_i,  // [9:0] sample
  input  logic                 s_axis_tuser_i,  // [0] frame_start
  output logic                 m_axis_tvalid_o,
  input  logic                 m_axis_tready_i,
  output logic [63:0]          m_axis_tdata_o,  // red, green, blue, out_column, out_row
  output logic                 m_axis_tlast_o,  // row_end
  output logic                 m_axis_tuser_o,  // [0] frame_end
  input  logic                 cfg_valid_i,
  output logic                 cfg_ready_o,
  input  logic [CFG_IDX_W-1:0] cfg_index_i,
  input  logic [CFG_W-1:0]     cfg_data_i
);

  logic             accept, b_adv;
  logic [COL_W-1:0] rd_addr, b_addr_q;
  tag_t             tag, b_tag_q;
  logic             b_valid_q;
  pix_t             b_sample_q;
  lines_t           rdata, word, wdata, fwd_word_q;
  logic             fwd_q;
  column_t          column;
  rgb_t             rgb, out_rgb_q;
  tag_t             out_tag_q;
  logic             out_valid_q;

  assign cfg_ready_o     = 1'b1;
  assign b_adv           = b_valid_q && (!out_valid_q || m_axis_tready_i);
  assign s_axis_tready_o = !b_valid_q || b_adv;
  assign accept          = s_axis_tvalid_i && s_axis_tready_o;

  bdb_ctrl u_ctrl (
    .clk_i,
    .rst_ni,
    .cfg_valid_i,
    .cfg_index_i,
    .cfg_data_i,
    .accept_i      (accept),
    .frame_start_i (s_axis_tuser_i),
    .addr_o        (rd_addr),
    .tag_o         (tag)
  );

  bdb_ram #(
    .WIDTH ($bits(lines_t)),
    .DEPTH (MAX_WIDTH)
  ) u_line_ram (
    .clk_i,
    .we_i    (b_adv),
    .waddr_i (b_addr_q),
    .wdata_i (wdata),
    .re_i    (accept),
    .raddr_i (rd_addr),
    .rdata_o (rdata)
  );

  assign word   = fwd_q ? fwd_word_q : rdata;
  assign wdata  = {b_sample_q, word[2], word[1]};
  assign column = {b_sample_q, word};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      b_valid_q <= 1'b0;
      fwd_q     <= 1'b0;
    end else if (accept) begin
      b_valid_q <= 1'b1;
      fwd_q     <= b_adv && (b_addr_q == rd_addr);
    end else if (b_adv) begin
      b_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      b_tag_q    <= tag;
      b_sample_q <= s_axis_tdata_i[PIX_W-1:0];
      b_addr_q   <= rd_addr;
      fwd_word_q <= wdata;
    end
  end

  bdb_kernel u_kernel (
    .clk_i,
    .rst_ni,
    .advance_i (b_adv),
    .column_i  (column),
    .rgb_o     (rgb)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (b_adv && b_tag_q.emit) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (b_adv && b_tag_q.emit) begin
      out_rgb_q <= rgb;
      out_tag_q <= b_tag_q;
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = {6'b0, out_tag_q.out_row, out_tag_q.out_col,
                            out_rgb_q.blue, out_rgb_q.green, out_rgb_q.red};
  assign m_axis_tlast_o  = out_tag_q.row_end;
  assign m_axis_tuser_o  = out_tag_q.frame_end;

endmodule

>>> bench/bdb_bin_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bdb_bin_checker
// Watches the sample, result and register channels of the Bayer binner.
// Keeps its own copy of the line store, window, counters and geometry,
// works out the binned pixel for each accepted sample that completes a bin,
// and compares each accepted result, field by field, with the oldest pending
// binned pixel.
module bdb_bin_checker
  import bdb_pkg::*;
(
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 s_axis_tvalid_i,
  input  logic                 s_axis_tready_i,
  input  logic [15:0]          s_axis_tdata_i,  // [9:0] sample
  input  logic                 s_axis_tuser_i,  // [0] frame_start
  input  logic                 m_axis_tvalid_i,
  input  logic                 m_axis_tready_i,
  input  logic [63:0]          m_axis_tdata_i,  // red, green, blue, out_column, out_row
  input  logic                 m_axis_tlast_i,  // row_end
  input  logic                 m_axis_tuser_i,  // [0] frame_end
  input  logic                 cfg_valid_i,
  input  logic                 cfg_ready_i,
  input  logic [CFG_IDX_W-1:0] cfg_index_i,
  input  logic [CFG_W-1:0]     cfg_data_i,
  output int                   errors_o,
  output int                   pending_o
);

  localparam int STORE_DEPTH = 3 * MAX_WIDTH;

  typedef struct {
    sum_t                 red;
    sum_t                 green;
    sum_t                 blue;
    logic [OUT_POS_W-1:0] col;
    logic [OUT_POS_W-1:0] row;
    logic                 row_end;
    logic                 frame_end;
  } bin_pix_t;

  pix_t             line_mem [STORE_DEPTH];
  pix_t             win [12];
  logic [12:0]      col_cnt;
  logic [11:0]      row_cnt;
  logic [CFG_W-1:0] width_reg;
  logic [CFG_W-1:0] height_reg;
  bin_pix_t         binned_q [$];
  int               err_cnt = 0;
  int               pend_cnt = 0;

  assign errors_o  = err_cnt;
  assign pending_o = pend_cnt;

  initial begin
    foreach (line_mem[i]) line_mem[i] = '0;
  end

  function automatic int clamp_even(input logic [CFG_W-1:0] v, input int hi);
    int x;
    x = int'(v);
    if (x < 4) x = 4;
    if (x > hi) x = hi;
    return x & ~1;
  endfunction

  task automatic report_mismatch(input string msg);
    $display("mismatch at %0t: %s", $time, msg);
    err_cnt++;
  endtask

  task automatic compare_field(input string name, input int got, input int want);
    if (got != want) report_mismatch($sformatf("%s got %0d want %0d", name, got, want));
  endtask

  task automatic bin_sample(input pix_t s, input logic fs);
    int       w, h, c, r, ci, nxt, j, k;
    int       v [4];
    int       d [4][4];
    int       rs, gs, bs;
    bin_pix_t e;
    w = clamp_even(width_reg, MAX_WIDTH);
    h = clamp_even(height_reg, MAX_HEIGHT);
    if (fs) begin
      col_cnt = '0;
      row_cnt = '0;
    end
    c  = int'(col_cnt);
    r  = int'(row_cnt);
    ci = (c < MAX_WIDTH) ? c : 0;
    v[0] = int'(line_mem[(r % 3) * MAX_WIDTH + ci]);
    v[1] = int'(line_mem[((r + 1) % 3) * MAX_WIDTH + ci]);
    v[2] = int'(line_mem[((r + 2) % 3) * MAX_WIDTH + ci]);
    v[3] = int'(s);
    for (j = 0; j < 4; j++) begin
      d[j][3] = v[j];
      for (k = 0; k < 3; k++) d[j][2-k] = int'(win[k*4 + j]);
    end
    if ((c % 2 == 1) && (r % 2 == 1) && c >= 3 && r >= 3 && c < w && r < h) begin
      rs = d[1][1] + ((d[1][1] + d[1][3]) >> 1) + ((d[1][1] + d[3][1]) >> 1)
         + ((d[1][1] + d[1][3] + d[3][1] + d[3][3]) >> 2);
      gs = ((d[0][1] + d[1][0] + d[2][1] + d[1][2]) >> 2) + d[1][2] + d[2][1]
         + ((d[1][2] + d[2][3] + d[3][2] + d[2][1]) >> 2);
      bs = ((d[0][0] + d[2][0] + d[0][2] + d[2][2]) >> 2)
         + ((d[0][2] + d[2][2]) >> 1) + ((d[2][0] + d[2][2]) >> 1) + d[2][2];
      e.red       = sum_t'(rs);
      e.green     = sum_t'(gs);
      e.blue      = sum_t'(bs);
      e.col       = OUT_POS_W'((c - 3) >> 1);
      e.row       = OUT_POS_W'((r - 3) >> 1);
      e.row_end   = (c == w - 1);
      e.frame_end = (c == w - 1) && (r == h - 1);
      binned_q.push_back(e);
    end
    for (k = 2; k > 0; k--)
      for (j = 0; j < 4; j++) win[k*4 + j] = win[(k-1)*4 + j];
    for (j = 0; j < 4; j++) win[j] = pix_t'(v[j]);
    line_mem[(r % 3) * MAX_WIDTH + ci] = s;
    nxt = c + 1;
    if (nxt >= w) begin
      nxt = 0;
      r = r + 1;
      if (r >= h) r = 0;
    end
    col_cnt = 13'(nxt);
    row_cnt = 12'(r);
  endtask

  task automatic check_result();
    bin_pix_t e;
    if (binned_q.size() == 0) begin
      report_mismatch("result with no binned pixel pending");
      return;
    end
    e = binned_q.pop_front();
    compare_field("red", int'(m_axis_tdata_i[11:0]), int'(e.red));
    compare_field("green", int'(m_axis_tdata_i[23:12]), int'(e.green));
    compare_field("blue", int'(m_axis_tdata_i[35:24]), int'(e.blue));
    compare_field("out_column", int'(m_axis_tdata_i[46:36]), int'(e.col));
    compare_field("out_row", int'(m_axis_tdata_i[57:47]), int'(e.row));
    compare_field("tdata pad", int'(m_axis_tdata_i[63:58]), 0);
    compare_field("row_end", int'(m_axis_tlast_i), int'(e.row_end));
    compare_field("frame_end", int'(m_axis_tuser_i), int'(e.frame_end));
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      foreach (win[i]) win[i] = '0;
      col_cnt    = '0;
      row_cnt    = '0;
      width_reg  = CFG_W'(RESET_WIDTH);
      height_reg = CFG_W'(RESET_HEIGHT);
      binned_q.delete();
      pend_cnt   = 0;
    end else begin
      if (m_axis_tvalid_i && m_axis_tready_i) check_result();
      if (s_axis_tvalid_i && s_axis_tready_i)
        bin_sample(pix_t'(s_axis_tdata_i[PIX_W-1:0]), s_axis_tuser_i);
      if (cfg_valid_i && cfg_ready_i) begin
        if (cfg_index_i == REG_FRAME_WIDTH) width_reg = cfg_data_i;
        else if (cfg_index_i == REG_FRAME_HEIGHT) height_reg = cfg_data_i;
      end
      pend_cnt = binned_q.size();
    end
  end

endmodule

>>> bench/tb_bayer_demosaic_bin2x2.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_bayer_demosaic_bin2x2
// Stimulus and verdict for the Bayer demosaic binner. Runs a short directed
// frame of saturated samples, then a series of geometry settings (clamped
// extremes at full width and full height, geometry changed mid-frame,
// random small frames) with random samples, stray frame starts and random
// idling on both streams. A separate checker predicts and compares.
// ----------------------------------------------------------------------------
module tb_bayer_demosaic_bin2x2;
  import bdb_pkg::*;

  localparam int LIMIT        = 200_000;
  localparam int DRAIN_CYCLES = 6;

  logic                 clk_i     = 1'b0;
  logic                 rst_ni    = 1'b0;
  logic                 s_tvalid  = 1'b0;
  logic                 s_tready;
  logic [15:0]          s_tdata   = '0;
  logic                 s_tuser   = 1'b0;
  logic                 m_tvalid;
  logic                 m_tready  = 1'b0;
  logic [63:0]          m_tdata;
  logic                 m_tlast;
  logic                 m_tuser;
  logic                 cfg_valid = 1'b0;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = REG_FRAME_WIDTH;
  logic [CFG_W-1:0]     cfg_data  = '0;
  int                   err_cnt;
  int                   pend_cnt;
  int                   cycle_cnt = 0;
  int                   sink_cnt  = 0;
  logic                 idling_on = 1'b1;

  always #6 clk_i = ~clk_i;

  bayer_demosaic_bin2x2 dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_tvalid),
    .s_axis_tready_o (s_tready),
    .s_axis_tdata_i  (s_tdata),
    .s_axis_tuser_i  (s_tuser),
    .m_axis_tvalid_o (m_tvalid),
    .m_axis_tready_i (m_tready),
    .m_axis_tdata_o  (m_tdata),
    .m_axis_tlast_o  (m_tlast),
    .m_axis_tuser_o  (m_tuser),
    .cfg_valid_i     (cfg_valid),
    .cfg_ready_o     (cfg_ready),
    .cfg_index_i     (cfg_index),
    .cfg_data_i      (cfg_data)
  );

  bdb_bin_checker u_checker (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_tvalid),
    .s_axis_tready_i (s_tready),
    .s_axis_tdata_i  (s_tdata),
    .s_axis_tuser_i  (s_tuser),
    .m_axis_tvalid_i (m_tvalid),
    .m_axis_tready_i (m_tready),
    .m_axis_tdata_i  (m_tdata),
    .m_axis_tlast_i  (m_tlast),
    .m_axis_tuser_i  (m_tuser),
    .cfg_valid_i     (cfg_valid),
    .cfg_ready_i     (cfg_ready),
    .cfg_index_i     (cfg_index),
    .cfg_data_i      (cfg_data),
    .errors_o        (err_cnt),
    .pending_o       (pend_cnt)
  );

  // stall the result stream in random bursts while idling is on
  always @(posedge clk_i) begin
    if (sink_cnt > 0) begin
      sink_cnt <= sink_cnt - 1;
    end else if (!m_tready) begin
      m_tready <= 1'b1;
      sink_cnt <= $urandom_range(0, 3) == 0 ? $urandom_range(20, 60) : $urandom_range(0, 19);
    end else if (idling_on) begin
      m_tready <= 1'b0;
      sink_cnt <= $urandom_range(0, 9);
    end
  end

  initial begin
    while (cycle_cnt < LIMIT) begin
      @(posedge clk_i);
      cycle_cnt++;
    end
    $display("FAIL");
    $finish;
  end

  task automatic write_geometry(input logic [CFG_W-1:0] wv, input logic [CFG_W-1:0] hv);
    cfg_valid <= 1'b1;
    cfg_index <= REG_FRAME_WIDTH;
    cfg_data  <= wv;
    do @(posedge clk_i); while (!cfg_ready);
    cfg_index <= REG_FRAME_HEIGHT;
    cfg_data  <= hv;
    do @(posedge clk_i); while (!cfg_ready);
    cfg_valid <= 1'b0;
  endtask

  task automatic send_item(input pix_t sample, input logic fs);
    if (idling_on && $urandom_range(0, 7) == 0) begin
      s_tvalid <= 1'b0;
      repeat ($urandom_range(1, 10)) @(posedge clk_i);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= {6'b0, sample};
    s_tuser  <= fs;
    do @(posedge clk_i); while (!s_tready);
  endtask

  task automatic wait_drained();
    s_tvalid <= 1'b0;
    @(negedge clk_i);
    while (pend_cnt != 0) @(negedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  task automatic run_phase(input logic [CFG_W-1:0] wv, input logic [CFG_W-1:0] hv,
                           input int n, input logic start_fs, input logic noise);
    pix_t smp;
    logic fs;
    write_geometry(wv, hv);
    for (int i = 0; i < n; i++) begin
      case ($urandom_range(0, 9))
        0:       smp = '0;
        1:       smp = '1;
        default: smp = pix_t'($urandom_range(0, 1023));
      endcase
      fs = (i == 0 && start_fs) || (noise && $urandom_range(0, 199) == 0);
      send_item(smp, fs);
    end
    wait_drained();
  endtask

  initial begin
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // saturated 4x4 frame, then a frame cut short by a new frame start
    write_geometry(CFG_W'(4), CFG_W'(4));
    for (int i = 0; i < 16; i++) send_item(pix_t'(1023), i == 0);
    for (int i = 0; i < 8; i++) send_item(pix_t'(0), i == 0);
    wait_drained();

    run_phase(CFG_W'(0), CFG_W'(0), 64, 1'b1, 1'b1);
    run_phase(CFG_W'(8191), CFG_W'(3), 64, 1'b1, 1'b0);
    run_phase(CFG_W'(5), CFG_W'(8191), 192, 1'b1, 1'b1);
    run_phase(CFG_W'(7), CFG_W'(9), 144, 1'b1, 1'b1);
    // shrink geometry mid-frame once rows 0..4 are stored
    run_phase(CFG_W'(16), CFG_W'(8), 83, 1'b1, 1'b0);
    run_phase(CFG_W'(10), CFG_W'(6), 120, 1'b0, 1'b0);
    run_phase(CFG_W'(12), CFG_W'(4), 100, 1'b0, 1'b1);
    repeat (6) begin
      run_phase(CFG_W'($urandom_range(4, 48)), CFG_W'($urandom_range(4, 24)),
                $urandom_range(100, 180), 1'b1, 1'b1);
    end
    idling_on = 1'b0;
    run_phase(CFG_W'(8), CFG_W'(6), 200, 1'b1, 1'b1);

    @(negedge clk_i);
    if (err_cnt == 0 && pend_cnt == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
